### rtl/md2v_pkg.sv
// ----------------------------------------------------------------------------
// md2v_pkg
// Shared types, constants and substitution table of the md2 variant hash.
// ----------------------------------------------------------------------------
package md2v_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int WORK_BYTES  = 48;
    localparam int PASSES      = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD_RD,
        ST_LOAD,
        ST_PASS,
        ST_FOLD,
        ST_CSUM,
        ST_EMIT
    } state_t;

    typedef logic [255:0][7:0] sbox_t;

    localparam sbox_t SBOX = {
        8'hab, 8'h43, 8'hff, 8'h4c, 8'he9, 8'hb9, 8'h39, 8'h29,
        8'hcf, 8'h83, 8'h9a, 8'h69, 8'h09, 8'hc9, 8'h1c, 8'ha7,
        8'h2f, 8'h5c, 8'h76, 8'hdd, 8'h2e, 8'hae, 8'hd6, 8'h49,
        8'hef, 8'h44, 8'h81, 8'h10, 8'hd4, 8'h7a, 8'h6d, 8'h64,
        8'ha5, 8'h9d, 8'h98, 8'haa, 8'h28, 8'hb1, 8'h54, 8'h25,
        8'h97, 8'h87, 8'hc7, 8'h26, 8'heb, 8'hf8, 8'h73, 8'h1d,
        8'hb5, 8'h40, 8'hf9, 8'h82, 8'h7b, 8'h2d, 8'h7e, 8'hbe,
        8'h46, 8'h65, 8'h0f, 8'h3b, 8'h6f, 8'hc4, 8'h38, 8'h16,
        8'he2, 8'h01, 8'he0, 8'h58, 8'h4f, 8'hc8, 8'h20, 8'h47,
        8'h0d, 8'h59, 8'h91, 8'hb2, 8'h70, 8'hcc, 8'hc5, 8'hb4,
        8'h6c, 8'h3d, 8'hca, 8'h63, 8'h57, 8'hc2, 8'he5, 8'h85,
        8'h5e, 8'h0b, 8'h1f, 8'had, 8'h51, 8'h55, 8'h8f, 8'h18,
        8'he3, 8'h61, 8'hd5, 8'h75, 8'h02, 8'h5d, 8'h05, 8'h5b,
        8'ha3, 8'h22, 8'h8b, 8'h6a, 8'h7c, 8'hd2, 8'hc0, 8'hd7,
        8'hc6, 8'h62, 8'h89, 8'h79, 8'h03, 8'h6b, 8'h37, 8'hfc,
        8'h77, 8'hed, 8'h0a, 8'hbc, 8'h0e, 8'h96, 8'hde, 8'h3a,
        8'hbf, 8'he4, 8'hd3, 8'h74, 8'h71, 8'hb7, 8'h99, 8'h94,
        8'h2b, 8'h8e, 8'h88, 8'ha1, 8'h11, 8'h35, 8'hb3, 8'hec,
        8'h4e, 8'h06, 8'h3c, 8'hba, 8'h12, 8'h50, 8'h8d, 8'h14,
        8'hcd, 8'hdb, 8'hf6, 8'h19, 8'h42, 8'h8a, 8'h7f, 8'hf4,
        8'hfa, 8'h84, 8'h00, 8'h86, 8'h6e, 8'h15, 8'h08, 8'h8c,
        8'h72, 8'ha4, 8'h92, 8'hf3, 8'h53, 8'h1e, 8'he6, 8'h48,
        8'h60, 8'hb8, 8'h07, 8'he8, 8'he7, 8'h90, 8'h66, 8'hf5,
        8'h17, 8'h67, 8'hc1, 8'h52, 8'h23, 8'haf, 8'h24, 8'h78,
        8'h0c, 8'hd8, 8'h3f, 8'ha6, 8'hf0, 8'h13, 8'ha9, 8'h34,
        8'ha8, 8'hce, 8'hfe, 8'h1a, 8'h95, 8'hfb, 8'hee, 8'h3e,
        8'h36, 8'h80, 8'h5f, 8'h27, 8'hc3, 8'h2c, 8'h68, 8'ha0,
        8'hda, 8'h9e, 8'h4d, 8'h4a, 8'hd9, 8'he1, 8'h9f, 8'h41,
        8'h5a, 8'h21, 8'hbb, 8'h31, 8'h9b, 8'h45, 8'hcb, 8'hf7,
        8'h4b, 8'h32, 8'hdf, 8'h7d, 8'hdc, 8'hb6, 8'h04, 8'h30,
        8'hd0, 8'hfd, 8'h33, 8'h1b, 8'h9c, 8'hd1, 8'h93, 8'hb0,
        8'h2a, 8'hac, 8'hf1, 8'ha2, 8'hf2, 8'hea, 8'h56, 8'hbd
    };

    function automatic logic [7:0] sbox_lookup(input logic [7:0] idx);
        return SBOX[idx];
    endfunction

endpackage

### rtl/md2v_core.sv
// ----------------------------------------------------------------------------
// md2v_core
// Block compression and checksum sequencer around a 48-byte work memory.
// ----------------------------------------------------------------------------
module md2v_core
    import md2v_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_has,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    // work memory: entries 0..15 from state, 16..31 block, 32..47 state^block
    logic [7:0] work_mem [WORK_BYTES];
    logic [7:0] state_mem [BLOCK_BYTES];
    logic [7:0] csum_mem [BLOCK_BYTES];
    logic [7:0] blk_mem [BLOCK_BYTES];

    state_t     state_reg, state_next;
    logic [4:0] fill_reg, fill_next;
    logic [5:0] k_reg, k_next;
    logic [4:0] pass_reg, pass_next;
    logic [7:0] t_reg, t_next;
    logic       ct_reg, ct_next;
    logic       fin_reg, fin_next;     // pad block absorbed, checksum next
    logic       pend_reg, pend_next;   // end mark waits behind a full block
    logic       use_csum_reg, use_csum_next;  // compressing the checksum
    logic [7:0] pad_reg, pad_next;

    logic [7:0] rd_state, rd_blk, rd_csum, rd_work;
    logic [5:0] wrd_addr;
    logic [3:0] k4;
    logic [7:0] src, blk_b, lk, newt;
    logic [7:0] out_reg;
    logic       out_valid_reg, out_last_reg;
    logic [4:0] clr_reg;

    assign k4 = k_reg[3:0];
    assign blk_b = use_csum_reg ? rd_csum : rd_blk;
    assign lk = sbox_lookup(8'(8'd48 - {2'd0, k_reg} + t_reg));

    always_comb begin
        case (k_reg[5:4])
            2'd0:    src = rd_state;
            2'd1:    src = blk_b;
            default: src = rd_state ^ blk_b;
        endcase
    end

    assign newt = (state_reg == ST_LOAD) ? (src ^ lk) : (rd_work ^ lk);

    // synchronous reads at the current index
    always_ff @(posedge aclk) begin
        rd_state <= state_mem[k4];
        rd_blk   <= blk_mem[k4];
        rd_csum  <= csum_mem[k4];
        rd_work  <= work_mem[wrd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        k_next        = k_reg;
        pass_next     = pass_reg;
        t_next        = t_reg;
        ct_next       = ct_reg;
        fin_next      = fin_reg;
        pend_next     = pend_reg;
        use_csum_next = use_csum_reg;
        pad_next      = pad_reg;
        in_ready      = 1'b0;
        wrd_addr      = k_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = clr_reg[4];
                k_next   = '0;
                if (in_valid && clr_reg[4]) begin
                    fin_next = 1'b0;
                    pad_next = 8'(5'd16 - {1'b0, fill_reg[3:0]});
                    if (in_has) begin
                        fill_next = fill_reg + 5'd1;
                        pad_next  = 8'(5'd15 - {1'b0, fill_reg[3:0]});
                        if (fill_reg == 5'd15) begin
                            fill_next     = '0;
                            pad_next      = 8'd16;
                            pend_next     = in_end;
                            use_csum_next = 1'b0;
                            t_next        = '0;
                            state_next    = ST_LOAD_RD;
                        end else if (in_end) begin
                            k_next     = {1'b0, fill_reg + 5'd1};
                            state_next = ST_PAD;
                        end
                    end else if (in_end) begin
                        k_next     = {1'b0, fill_reg};
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                k_next = k_reg + 6'd1;
                if (k_reg == 6'd15) begin
                    k_next        = '0;
                    fin_next      = 1'b1;
                    fill_next     = '0;
                    pad_next      = 8'd16;
                    use_csum_next = 1'b0;
                    t_next        = '0;
                    state_next    = ST_LOAD_RD;
                end
            end
            ST_LOAD_RD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // data read in ST_LOAD_RD is used now; the next index is read in ST_LOAD_RD
                t_next = newt;
                k_next = k_reg + 6'd1;
                if (k_reg == 6'd47) begin
                    k_next     = '0;
                    pass_next  = '0;
                    state_next = ST_PASS;
                end else begin
                    state_next = ST_LOAD_RD;
                end
            end
            ST_PASS: begin
                // ct_reg=0: reading, ct_reg=1: compute and write one entry
                if (ct_reg == 1'b0) begin
                    ct_next = 1'b1;
                end else begin
                    ct_next = 1'b0;
                    t_next  = newt;
                    k_next  = k_reg + 6'd1;
                    if (k_reg == 6'd47) begin
                        k_next    = '0;
                        pass_next = pass_reg + 5'd1;
                        if (pass_reg == 5'(PASSES - 1)) begin
                            state_next = ST_FOLD;
                        end
                    end
                end
            end
            ST_FOLD: begin
                if (ct_reg == 1'b0) begin
                    ct_next = 1'b1;
                end else begin
                    ct_next = 1'b0;
                    t_next  = newt;
                    k_next  = k_reg + 6'd1;
                    if (k_reg == 6'd15) begin
                        k_next = '0;
                        if (use_csum_reg) begin
                            state_next = ST_EMIT;
                        end else begin
                            ct_next    = 1'b1;
                            state_next = ST_CSUM;
                        end
                    end
                end
            end
            ST_CSUM: begin
                // ct_reg=1: reading, then update one entry
                if (ct_reg == 1'b1) begin
                    ct_next = 1'b0;
                end else begin
                    k_next = k_reg + 6'd1;
                    ct_next = 1'b1;
                    if (k_reg == 6'd15) begin
                        k_next  = '0;
                        ct_next = 1'b0;
                        if (fin_reg) begin
                            use_csum_next = 1'b1;
                            t_next        = '0;
                            state_next    = ST_LOAD_RD;
                        end else if (pend_reg) begin
                            // end mark came with the byte that filled the block
                            pend_next  = 1'b0;
                            state_next = ST_PAD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || out_ready) begin
                    if (ct_reg == 1'b0) begin
                        ct_next = 1'b1;
                    end else begin
                        ct_next = 1'b0;
                        k_next  = k_reg + 6'd1;
                        if (k_reg == 6'd15) begin
                            k_next        = '0;
                            fin_next      = 1'b0;
                            use_csum_next = 1'b0;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // checksum chain byte: previous entry, or entry 15 at start
    logic [7:0] csum_prev_reg;
    logic [7:0] csum_new;
    assign csum_new = rd_csum ^ sbox_lookup(rd_blk ^ csum_prev_reg);

    // clear sweep of state and checksum stores after reset, then all writes
    always_ff @(posedge aclk) begin
        if (!clr_reg[4]) begin
            state_mem[clr_reg[3:0]] <= 8'd0;
            csum_mem[clr_reg[3:0]]  <= 8'd0;
        end else begin
            if (state_reg == ST_IDLE && in_valid && in_ready && in_has) begin
                blk_mem[fill_reg[3:0]] <= in_byte;
            end
            if (state_reg == ST_PAD) begin
                blk_mem[k4] <= pad_reg;
            end
            if (state_reg == ST_LOAD) begin
                work_mem[k_reg] <= newt;
            end
            if ((state_reg == ST_PASS) && ct_reg) begin
                work_mem[k_reg] <= newt;
            end
            if ((state_reg == ST_FOLD) && ct_reg) begin
                state_mem[k4] <= newt;
            end
            if ((state_reg == ST_CSUM) && !ct_reg) begin
                csum_mem[k4] <= csum_new;
                csum_prev_reg <= csum_new;
            end
            if ((state_reg == ST_FOLD) && ct_reg && k_reg == 6'd15) begin
                csum_prev_reg <= csum_mem[4'd15];
            end
            if ((state_reg == ST_EMIT) && ct_reg && (!out_valid_reg || out_ready)) begin
                out_reg <= rd_state;
                state_mem[k4] <= 8'd0;
                csum_mem[k4]  <= 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (!clr_reg[4]) begin
            clr_reg <= clr_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            k_reg         <= '0;
            pass_reg      <= '0;
            t_reg         <= '0;
            ct_reg        <= 1'b0;
            fin_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            use_csum_reg  <= 1'b0;
            pad_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            state_reg    <= (!clr_reg[4]) ? ST_IDLE : state_next;
            fill_reg     <= fill_next;
            k_reg        <= k_next;
            pass_reg     <= pass_next;
            t_reg        <= t_next;
            ct_reg       <= ct_next;
            fin_reg      <= fin_next;
            pend_reg     <= pend_next;
            use_csum_reg <= use_csum_next;
            pad_reg      <= pad_next;
            if ((state_reg == ST_EMIT) && ct_reg && (!out_valid_reg || out_ready)) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= (k_reg == 6'd15);
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/md2_variant_sbox_hash_top.sv
// a full block takes 48 load steps, 768 pass steps and 16 fold steps, each
// a read then a compute, and then the checksum update; the work memory has
// a single read port, and no input byte is accepted until the block is done
// end of message: pad, two compressions (three when the last byte fills a
// block), then 16 digest words; input waits meanwhile
// reset: synchronous active low; clearing sweep of the state
// and checksum memories, during which no word is accepted
// ----------------------------------------------------------------------------
// md2_variant_sbox_hash_top
// Byte-serial md2-style hash with stream input and digest output.
// ----------------------------------------------------------------------------
module md2_variant_sbox_hash_top
    import md2v_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] digest_byte
    output logic        m_tlast
);

    md2v_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_has    (s_tuser),
        .in_end    (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/md2v_checker.sv
// ----------------------------------------------------------------------------
// md2v_checker
// Port-level checks of the hash block.
// ----------------------------------------------------------------------------
module md2v_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("output word right after last digest word");

    a_no_in_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input ready during clearing sweep");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind md2_variant_sbox_hash_top md2v_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### verif/md2_variant_sbox_hash_top_tb.sv
// ----------------------------------------------------------------------------
// md2_variant_sbox_hash_top_tb
// Streams messages into the hash block and checks every digest word against
// a behavioral model of the padding, compression and checksum path.
// ----------------------------------------------------------------------------
module md2_variant_sbox_hash_top_tb;
    import md2v_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    md2_variant_sbox_hash_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tuser  (s_tuser),   // [0] has_byte
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] digest_byte
        .m_tlast  (m_tlast)
    );

    typedef struct packed {
        logic [7:0] dbyte;
        logic       last;
    } digest_word_t;

    localparam logic [7:0] TABLE [256] = '{
        8'hbd, 8'h56, 8'hea, 8'hf2, 8'ha2, 8'hf1, 8'hac, 8'h2a,
        8'hb0, 8'h93, 8'hd1, 8'h9c, 8'h1b, 8'h33, 8'hfd, 8'hd0,
        8'h30, 8'h04, 8'hb6, 8'hdc, 8'h7d, 8'hdf, 8'h32, 8'h4b,
        8'hf7, 8'hcb, 8'h45, 8'h9b, 8'h31, 8'hbb, 8'h21, 8'h5a,
        8'h41, 8'h9f, 8'he1, 8'hd9, 8'h4a, 8'h4d, 8'h9e, 8'hda,
        8'ha0, 8'h68, 8'h2c, 8'hc3, 8'h27, 8'h5f, 8'h80, 8'h36,
        8'h3e, 8'hee, 8'hfb, 8'h95, 8'h1a, 8'hfe, 8'hce, 8'ha8,
        8'h34, 8'ha9, 8'h13, 8'hf0, 8'ha6, 8'h3f, 8'hd8, 8'h0c,
        8'h78, 8'h24, 8'haf, 8'h23, 8'h52, 8'hc1, 8'h67, 8'h17,
        8'hf5, 8'h66, 8'h90, 8'he7, 8'he8, 8'h07, 8'hb8, 8'h60,
        8'h48, 8'he6, 8'h1e, 8'h53, 8'hf3, 8'h92, 8'ha4, 8'h72,
        8'h8c, 8'h08, 8'h15, 8'h6e, 8'h86, 8'h00, 8'h84, 8'hfa,
        8'hf4, 8'h7f, 8'h8a, 8'h42, 8'h19, 8'hf6, 8'hdb, 8'hcd,
        8'h14, 8'h8d, 8'h50, 8'h12, 8'hba, 8'h3c, 8'h06, 8'h4e,
        8'hec, 8'hb3, 8'h35, 8'h11, 8'ha1, 8'h88, 8'h8e, 8'h2b,
        8'h94, 8'h99, 8'hb7, 8'h71, 8'h74, 8'hd3, 8'he4, 8'hbf,
        8'h3a, 8'hde, 8'h96, 8'h0e, 8'hbc, 8'h0a, 8'hed, 8'h77,
        8'hfc, 8'h37, 8'h6b, 8'h03, 8'h79, 8'h89, 8'h62, 8'hc6,
        8'hd7, 8'hc0, 8'hd2, 8'h7c, 8'h6a, 8'h8b, 8'h22, 8'ha3,
        8'h5b, 8'h05, 8'h5d, 8'h02, 8'h75, 8'hd5, 8'h61, 8'he3,
        8'h18, 8'h8f, 8'h55, 8'h51, 8'had, 8'h1f, 8'h0b, 8'h5e,
        8'h85, 8'he5, 8'hc2, 8'h57, 8'h63, 8'hca, 8'h3d, 8'h6c,
        8'hb4, 8'hc5, 8'hcc, 8'h70, 8'hb2, 8'h91, 8'h59, 8'h0d,
        8'h47, 8'h20, 8'hc8, 8'h4f, 8'h58, 8'he0, 8'h01, 8'he2,
        8'h16, 8'h38, 8'hc4, 8'h6f, 8'h3b, 8'h0f, 8'h65, 8'h46,
        8'hbe, 8'h7e, 8'h2d, 8'h7b, 8'h82, 8'hf9, 8'h40, 8'hb5,
        8'h1d, 8'h73, 8'hf8, 8'heb, 8'h26, 8'hc7, 8'h87, 8'h97,
        8'h25, 8'h54, 8'hb1, 8'h28, 8'haa, 8'h98, 8'h9d, 8'ha5,
        8'h64, 8'h6d, 8'h7a, 8'hd4, 8'h10, 8'h81, 8'h44, 8'hef,
        8'h49, 8'hd6, 8'hae, 8'h2e, 8'hdd, 8'h76, 8'h5c, 8'h2f,
        8'ha7, 8'h1c, 8'hc9, 8'h09, 8'h69, 8'h9a, 8'h83, 8'hcf,
        8'h29, 8'h39, 8'hb9, 8'he9, 8'h4c, 8'hff, 8'h43, 8'hab
    };

    // model copy of the block state, expected digest words and bench controls
    logic [7:0]   m_state [16];
    logic [7:0]   m_csum  [16];
    logic [7:0]   m_block [16];
    int           m_fill;
    digest_word_t digest_q [$];
    bit           failed;
    int           stall_hold;
    int           gap_max;

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    function automatic logic [7:0] tbl(int j, logic [7:0] t);
        return TABLE[(j + t) & 8'hff];
    endfunction

    task automatic compress_block(input logic [7:0] blk [16]);
        logic [7:0] w [48];
        logic [7:0] t;
        logic [7:0] src;
        t = 8'h00;
        for (int k = 0; k < 48; k++) begin
            if (k < 16) src = m_state[k];
            else if (k < 32) src = blk[k - 16];
            else src = m_state[k - 32] ^ blk[k - 32];
            t = src ^ tbl(48 - k, t);
            w[k] = t;
        end
        for (int p = 0; p < 16; p++) begin
            for (int k = 0; k < 48; k++) begin
                w[k] = w[k] ^ tbl(48 - k, t);
                t = w[k];
            end
        end
        for (int k = 0; k < 16; k++) begin
            t = w[k] ^ tbl(48 - k, t);
            m_state[k] = t;
        end
    endtask

    task automatic absorb_block(input logic [7:0] blk [16]);
        logic [7:0] t;
        compress_block(blk);
        t = m_csum[15];
        for (int i = 0; i < 16; i++) begin
            m_csum[i] = m_csum[i] ^ TABLE[blk[i] ^ t];
            t = m_csum[i];
        end
    endtask

    task automatic predict_digest(input logic [7:0] d, input logic has, input logic eom);
        int pad;
        if (has) begin
            m_block[m_fill] = d;
            m_fill++;
            if (m_fill == 16) begin
                absorb_block(m_block);
                m_fill = 0;
            end
        end
        if (eom) begin
            pad = 16 - m_fill;
            for (int k = m_fill; k < 16; k++) m_block[k] = pad[7:0];
            absorb_block(m_block);
            compress_block(m_csum);
            for (int k = 0; k < 16; k++) digest_q.push_back('{m_state[k], k == 15});
            for (int k = 0; k < 16; k++) begin
                m_state[k] = 8'h00;
                m_csum[k] = 8'h00;
            end
            m_fill = 0;
        end
    endtask

    // one word on the input side, with a random gap ahead of it
    task automatic send_word(input logic [7:0] d, input logic has, input logic eom);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= has;
        s_tlast  <= eom;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_digest(d, has, eom);
        @(negedge aclk);
    endtask

    task automatic send_message(input int len, input bit byte_on_end);
        for (int i = 0; i < len; i++) begin
            if (byte_on_end && i == len - 1) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            else send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        if (!byte_on_end || len == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (digest_q.size() != 0);
    endtask

    task automatic test_directed();
        // empty message: one whole pad block
        send_word(8'h00, 1'b0, 1'b1);
        // byte extremes, then a byte carried on the end mark
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'haa, 1'b0, 1'b0);
        send_word(8'h55, 1'b1, 1'b1);
        // full block ending exactly on the end mark
        for (int i = 0; i < 15; i++) send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_block_boundaries();
        send_message(15, 1'b0);
        send_message(16, 1'b0);
        send_message(17, 1'b1);
        send_message(32, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // long enough to hold the first digest while the next message waits
        stall_hold = 8000;
        send_message(20, 1'b0);
        send_message(3, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        int len;
        gap_max = 6;
        for (int m = 0; m < 12; m++) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 15);
            // idle noise words that the block ignores
            if ($urandom_range(0, 3) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        wait_drained();
    endtask

    // receiver stall pattern plus the long hold-off
    initial begin
        m_tready = 1'b0;
        stall_hold = 0;
        forever begin
            @(negedge aclk);
            if (stall_hold > 0) begin
                m_tready <= 1'b0;
                stall_hold--;
            end else begin
                m_tready <= ($urandom_range(0, 7) > 1);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h last %b", $time, m_tdata, m_tlast);
                failed = 1'b1;
            end else begin
                digest_word_t e;
                e = digest_q.pop_front();
                if (m_tdata !== e.dbyte || m_tlast !== e.last) begin
                    $display("%0t: mismatch expected %h/%b actual %h/%b",
                             $time, e.dbyte, e.last, m_tdata, m_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        failed   = 1'b0;
        gap_max  = 3;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        m_fill   = 0;
        for (int k = 0; k < 16; k++) begin
            m_state[k] = 8'h00;
            m_csum[k]  = 8'h00;
            m_block[k] = 8'h00;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_block_boundaries();
        test_backpressure();
        test_random();
        repeat (200) @(negedge aclk);
        if (!failed) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/md2v_pkg.sv
rtl/md2v_core.sv
rtl/md2_variant_sbox_hash_top.sv
rtl/md2v_checker.sv
verif/md2_variant_sbox_hash_top_tb.sv
